/* hdl/rid_pkg.sv */
// ============================================================================
// rid_pkg: shared types for the restoring integer divider
// Flag bundle that travels alongside each request through the divider array.
// ============================================================================
`default_nettype none

package rid_pkg;

  // Per-request side information, fixed at the front and used at the back
  typedef struct packed {
    logic neg;    // operand signs differ, negate the quotient
    logic dzero;  // divisor is zero, force quotient to zero
  } rid_flags_t;

endpackage : rid_pkg

`default_nettype wire

/* hdl/rid_prep.sv */
// ============================================================================
// rid_prep: operand front stage
// Takes magnitudes of signed operands and registers them for the cell array.
// ============================================================================
`default_nettype none

module rid_prep import rid_pkg::*; #(
  parameter int unsigned DataWidth = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output      logic                 ready_o,
  input  wire logic                 kind_i,
  input  wire logic [DataWidth-1:0] numerator_i,
  input  wire logic [DataWidth-1:0] divisor_i,
  output      logic                 valid_o,
  input  wire logic                 ready_i,
  output      logic [DataWidth-1:0] rem_o,
  output      logic [DataWidth-1:0] work_o,
  output      logic [DataWidth-1:0] den_o,
  output      rid_flags_t           flags_o
);

  logic                 valid_q;
  logic [DataWidth-1:0] work_q, work_d;
  logic [DataWidth-1:0] den_q, den_d;
  rid_flags_t           flags_q, flags_d;
  logic                 num_neg, den_neg;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    num_neg       = kind_i & numerator_i[DataWidth-1];
    den_neg       = kind_i & divisor_i[DataWidth-1];
    work_d        = num_neg ? (~numerator_i + 1'b1) : numerator_i;
    den_d         = den_neg ? (~divisor_i + 1'b1) : divisor_i;
    flags_d.neg   = num_neg ^ den_neg;
    flags_d.dzero = (divisor_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      work_q  <= work_d;
      den_q   <= den_d;
      flags_q <= flags_d;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = '0;
  assign work_o  = work_q;
  assign den_o   = den_q;
  assign flags_o = flags_q;

endmodule : rid_prep

`default_nettype wire

/* hdl/rid_cell.sv */
// ============================================================================
// rid_cell: one restoring division step
// Shifts in the next dividend bit, trial-subtracts the divisor, registers.
// ============================================================================
`default_nettype none

module rid_cell import rid_pkg::*; #(
  parameter int unsigned DataWidth = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output      logic                 ready_o,
  input  wire logic [DataWidth-1:0] rem_i,
  input  wire logic [DataWidth-1:0] work_i,
  input  wire logic [DataWidth-1:0] den_i,
  input  wire rid_flags_t           flags_i,
  output      logic                 valid_o,
  input  wire logic                 ready_i,
  output      logic [DataWidth-1:0] rem_o,
  output      logic [DataWidth-1:0] work_o,
  output      logic [DataWidth-1:0] den_o,
  output      rid_flags_t           flags_o
);

  logic                 valid_q;
  logic [DataWidth-1:0] rem_q, rem_d;
  logic [DataWidth-1:0] work_q, work_d;
  logic [DataWidth-1:0] den_q;
  rid_flags_t           flags_q;
  logic [DataWidth:0]   shifted;
  logic [DataWidth+1:0] diff;
  logic                 fits;

  assign ready_o = !valid_q || ready_i;

  // work holds unused dividend bits on top, quotient bits collect at the bottom
  always_comb begin
    shifted = {rem_i, work_i[DataWidth-1]};
    diff    = {1'b0, shifted} - {2'b00, den_i};
    fits    = !diff[DataWidth+1];
    rem_d   = fits ? diff[DataWidth-1:0] : shifted[DataWidth-1:0];
    work_d  = {work_i[DataWidth-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      rem_q   <= rem_d;
      work_q  <= work_d;
      den_q   <= den_i;
      flags_q <= flags_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign work_o  = work_q;
  assign den_o   = den_q;
  assign flags_o = flags_q;

endmodule : rid_cell

`default_nettype wire

/* hdl/rid_post.sv */
// ============================================================================
// rid_post: quotient fix-up and output register
// Applies the zero-divisor rule and sign correction, holds the result.
// ============================================================================
`default_nettype none

module rid_post import rid_pkg::*; #(
  parameter int unsigned DataWidth = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output      logic                 ready_o,
  input  wire logic [DataWidth-1:0] work_i,
  input  wire rid_flags_t           flags_i,
  output      logic                 valid_o,
  input  wire logic                 stall_i,
  output      logic [DataWidth-1:0] quotient_o
);

  logic                 valid_q;
  logic [DataWidth-1:0] quot_q, quot_d;

  assign ready_o = !valid_q || !stall_i;

  always_comb begin
    if (flags_i.dzero) begin
      quot_d = '0;
    end else if (flags_i.neg) begin
      quot_d = ~work_i + 1'b1;
    end else begin
      quot_d = work_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      quot_q <= quot_d;
    end
  end

  assign valid_o    = valid_q;
  assign quotient_o = quot_q;

endmodule : rid_post

`default_nettype wire

/* hdl/restoring_integer_divider_top.sv */
// ============================================================================
// restoring_integer_divider_top: pipelined restoring divider
// Signed/unsigned integer quotient through a chain of one-bit division cells.
// ============================================================================
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | request   | in_valid_i / in_stall_o | in_kind_i, in_numerator_i,
//          |           |                        | in_divisor_i
//  out     | result    | out_valid_o/out_stall_i | out_quotient_o
//
//  The path is one operand stage, DATA_WIDTH division
//  cells (one quotient bit each, MSB first) and one output register.
//  A new request is taken every cycle while the output side drains.
//  Each stage advances when its successor is empty or advancing, so bubbles
//  collapse and requests keep entering while a finished result is stalled.
//  Reset (rst_ni, async, active low) clears only the stage valid bits.
// ============================================================================
`default_nettype none

module restoring_integer_divider_top import rid_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // request channel
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire logic                  in_kind_i,
  input  wire logic [DATA_WIDTH-1:0] in_numerator_i,
  input  wire logic [DATA_WIDTH-1:0] in_divisor_i,
  // result channel
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      logic [DATA_WIDTH-1:0] out_quotient_o
);

  // Stage k feeds cell k; stage DATA_WIDTH feeds the output stage.
  logic                  stg_valid [DATA_WIDTH+1];
  logic                  stg_ready [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] stg_rem   [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] stg_work  [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] stg_den   [DATA_WIDTH+1];
  rid_flags_t            stg_flags [DATA_WIDTH+1];
  logic                  prep_ready;

  assign in_stall_o = !prep_ready;

  // Operand stage: magnitudes and sign / zero-divisor flags
  rid_prep #(
    .DataWidth (DATA_WIDTH)
  ) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_i),
    .ready_o     (prep_ready),
    .kind_i      (in_kind_i),
    .numerator_i (in_numerator_i),
    .divisor_i   (in_divisor_i),
    .valid_o     (stg_valid[0]),
    .ready_i     (stg_ready[0]),
    .rem_o       (stg_rem[0]),
    .work_o      (stg_work[0]),
    .den_o       (stg_den[0]),
    .flags_o     (stg_flags[0])
  );

  // One cell per quotient bit
  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_cell
    rid_cell #(
      .DataWidth (DATA_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[k]),
      .ready_o (stg_ready[k]),
      .rem_i   (stg_rem[k]),
      .work_i  (stg_work[k]),
      .den_i   (stg_den[k]),
      .flags_i (stg_flags[k]),
      .valid_o (stg_valid[k+1]),
      .ready_i (stg_ready[k+1]),
      .rem_o   (stg_rem[k+1]),
      .work_o  (stg_work[k+1]),
      .den_o   (stg_den[k+1]),
      .flags_o (stg_flags[k+1])
    );
  end

  // Sign fix-up and result register; the final remainder and divisor
  // are not needed past the last cell.
  rid_post #(
    .DataWidth (DATA_WIDTH)
  ) u_post (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (stg_valid[DATA_WIDTH]),
    .ready_o    (stg_ready[DATA_WIDTH]),
    .work_i     (stg_work[DATA_WIDTH]),
    .flags_i    (stg_flags[DATA_WIDTH]),
    .valid_o    (out_valid_o),
    .stall_i    (out_stall_i),
    .quotient_o (out_quotient_o)
  );

`ifndef SYNTHESIS
  // An empty output register means the whole chain can move
  a_empty_out_accepts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("request stalled with empty output register");

  // Back-pressure only originates from the result side
  a_stall_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i)
    else $error("request stalled without result stall");

  // Zero divisor always yields a zero quotient
  a_zero_divisor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_valid[DATA_WIDTH] && stg_ready[DATA_WIDTH] && stg_flags[DATA_WIDTH].dzero)
    |=> (out_quotient_o == '0))
    else $error("nonzero quotient for zero divisor");

  // Results with a nonzero divisor and no negation leave the cell array quotient unchanged
  a_pass_through : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_valid[DATA_WIDTH] && stg_ready[DATA_WIDTH] && !stg_flags[DATA_WIDTH].dzero
     && !stg_flags[DATA_WIDTH].neg)
    |=> (out_quotient_o == $past(stg_work[DATA_WIDTH])))
    else $error("same-sign quotient altered in output stage");
`endif

endmodule : restoring_integer_divider_top

`default_nettype wire
